### sv/assert_macros.svh
// Assertion macros used by the top-level RTL file of the line diff cost cell.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LCD_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("Assertion failed.");
`define LCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("Assertion failed.");
`else
`define LCD_ASSERT(label, clk, rst_n, prop)
`define LCD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### sv/lcd_pkg.sv
`timescale 1ns / 1ps

package lcd_pkg;

  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  localparam logic [1:0] REG_ROWS_IN_USE       = 2'd0;
  localparam logic [1:0] REG_DELETE_COST       = 2'd1;
  localparam logic [1:0] REG_BLOCK_DELETE_COST = 2'd2;
  localparam logic [1:0] REG_ADD_BASE_COST     = 2'd3;

  localparam logic [10:0] RESET_ROWS_IN_USE       = 11'd1;
  localparam logic [7:0]  RESET_DELETE_COST       = 8'd10;
  localparam logic [7:0]  RESET_BLOCK_DELETE_COST = 8'd15;
  localparam logic [7:0]  RESET_ADD_BASE_COST     = 8'd10;

  typedef struct packed {
    logic [10:0] rows_in_use;
    logic [7:0]  delete_cost;
    logic [7:0]  block_delete_cost;
    logic [7:0]  add_base_cost;
  } lcd_cfg_t;

  typedef enum logic [1:0] {
    MOVE_SUB       = 2'd0,
    MOVE_ADD       = 2'd1,
    MOVE_BLOCK_DEL = 2'd2,
    MOVE_DEL       = 2'd3
  } lcd_move_e;

endpackage

### sv/lcd_cell_if.sv
`timescale 1ns / 1ps

interface lcd_cell_if;
  logic        valid;
  logic        ready;
  logic [15:0] sub_cost;
  logic [15:0] line_length;
  logic        first_cell;

  modport source (output valid, output sub_cost, output line_length, output first_cell,
                  input ready);
  modport sink (input valid, input sub_cost, input line_length, input first_cell,
                output ready);
endinterface

### sv/lcd_result_if.sv
`timescale 1ns / 1ps

interface lcd_result_if;
  logic        valid;
  logic        ready;
  logic [23:0] cell_cost;
  logic [1:0]  pred_move;
  logic [10:0] pred_row;
  logic [10:0] row_index;
  logic        column_end;

  modport source (output valid, output cell_cost, output pred_move, output pred_row,
                  output row_index, output column_end, input ready);
  modport sink (input valid, input cell_cost, input pred_move, input pred_row,
                input row_index, input column_end, output ready);
endinterface

### sv/lcd_cfg_regs.sv
`timescale 1ns / 1ps

module lcd_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lcd_pkg::APB_AW-1:0]  paddr,
  input  logic [lcd_pkg::APB_DW-1:0]  pwdata,
  output logic [lcd_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output lcd_pkg::lcd_cfg_t           cfg_o,
  output lcd_pkg::lcd_cfg_t           cfg_next_o
);

  lcd_pkg::lcd_cfg_t cfg_q, cfg_d;
  logic              wr_en;
  logic [1:0]        reg_sel;

  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[lcd_pkg::APB_AW-1:2];
  assign pready  = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_sel)
        lcd_pkg::REG_ROWS_IN_USE:       cfg_d.rows_in_use       = pwdata[10:0];
        lcd_pkg::REG_DELETE_COST:       cfg_d.delete_cost       = pwdata[7:0];
        lcd_pkg::REG_BLOCK_DELETE_COST: cfg_d.block_delete_cost = pwdata[7:0];
        lcd_pkg::REG_ADD_BASE_COST:     cfg_d.add_base_cost     = pwdata[7:0];
        default:                        cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      lcd_pkg::REG_ROWS_IN_USE:       prdata = lcd_pkg::APB_DW'(cfg_q.rows_in_use);
      lcd_pkg::REG_DELETE_COST:       prdata = lcd_pkg::APB_DW'(cfg_q.delete_cost);
      lcd_pkg::REG_BLOCK_DELETE_COST: prdata = lcd_pkg::APB_DW'(cfg_q.block_delete_cost);
      lcd_pkg::REG_ADD_BASE_COST:     prdata = lcd_pkg::APB_DW'(cfg_q.add_base_cost);
      default:                        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rows_in_use       <= lcd_pkg::RESET_ROWS_IN_USE;
      cfg_q.delete_cost       <= lcd_pkg::RESET_DELETE_COST;
      cfg_q.block_delete_cost <= lcd_pkg::RESET_BLOCK_DELETE_COST;
      cfg_q.add_base_cost     <= lcd_pkg::RESET_ADD_BASE_COST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o      = cfg_q;
  assign cfg_next_o = cfg_d;

endmodule

### sv/lcd_col_mem.sv
`timescale 1ns / 1ps

module lcd_col_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned DW    = 24
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rd_q;
  logic [DW-1:0] fwd_data_q;
  logic          fwd_q;

  // A read of the address written in the same cycle returns the new data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rd_q       <= mem_q[raddr_i];
    fwd_q      <= we_i && (waddr_i == raddr_i);
    fwd_data_q <= wdata_i;
  end

  assign rdata_o = fwd_q ? fwd_data_q : rd_q;

endmodule

### sv/lcd_cell_dp.sv
`timescale 1ns / 1ps

module lcd_cell_dp #(
  parameter int unsigned MAX_ROWS  = 1024,
  parameter int unsigned COST_BITS = 24,
  localparam int unsigned RW = $clog2(MAX_ROWS + 1),
  localparam int unsigned AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   fire_i,
  input  logic [15:0]            sub_cost_i,
  input  logic [15:0]            line_length_i,
  input  logic                   first_cell_i,
  input  lcd_pkg::lcd_cfg_t      cfg_i,
  input  logic [RW-1:0]          rows_i,
  input  logic [COST_BITS-1:0]   mem_rdata_i,
  output logic                   mem_we_o,
  output logic [AW-1:0]          mem_waddr_o,
  output logic [COST_BITS-1:0]   mem_wdata_o,
  output logic [RW-1:0]          row_next_o,
  output logic [COST_BITS-1:0]   cell_cost_o,
  output lcd_pkg::lcd_move_e     pred_move_o,
  output logic [RW-1:0]          pred_row_o,
  output logic [RW-1:0]          row_index_o,
  output logic                   column_end_o
);

  localparam int unsigned CW = COST_BITS;

  function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CW] ? {CW{1'b1}} : s[CW-1:0];
  endfunction

  logic          first_column_q, first_column_d;
  logic [RW-1:0] row_counter_q, row_counter_d;
  logic [CW-1:0] diag_q, diag_d;
  logic [CW-1:0] above_q, above_d;
  logic [CW-1:0] run_min_q, run_min_d;
  logic [RW-1:0] run_min_row_q, run_min_row_d;
  logic [CW-1:0] top_q, top_d;

  logic               first_col;
  logic [RW-1:0]      rc;
  logic               start;
  logic [CW-1:0]      p0, top, diag, above, rmin;
  logic [RW-1:0]      rmin_row;
  logic [RW-1:0]      k;
  logic [CW-1:0]      prevk, via_sub, via_add, blk, del, best;
  lcd_pkg::lcd_move_e move;
  logic [RW-1:0]      prow;
  logic               last;

  always_comb begin
    first_col = first_cell_i | first_column_q;
    rc        = first_cell_i ? '0 : row_counter_q;
    if (rc >= rows_i) begin
      rc = '0;
    end
    start = (rc == '0);

    // Row zero of the column is derived from row zero of the previous column.
    p0       = first_col ? '0 : top_q;
    top      = sat_add(sat_add(p0, CW'(cfg_i.add_base_cost)), CW'(line_length_i));
    diag     = start ? p0 : diag_q;
    above    = start ? top : above_q;
    rmin     = start ? top : run_min_q;
    rmin_row = start ? '0 : run_min_row_q;

    k = rc + RW'(1);
    if (first_col) begin
      prevk = (k == RW'(1)) ? CW'(cfg_i.delete_cost) : CW'(cfg_i.block_delete_cost);
    end else begin
      prevk = mem_rdata_i;
    end

    via_sub = sat_add(diag, CW'(sub_cost_i));
    via_add = sat_add(sat_add(prevk, CW'(cfg_i.add_base_cost)), CW'(line_length_i));
    if (via_sub <= via_add) begin
      best = via_sub;
      move = lcd_pkg::MOVE_SUB;
      prow = rc;
    end else begin
      best = via_add;
      move = lcd_pkg::MOVE_ADD;
      prow = k;
    end

    blk = sat_add(rmin, CW'(cfg_i.block_delete_cost));
    if (best > blk) begin
      best = blk;
      move = lcd_pkg::MOVE_BLOCK_DEL;
      prow = rmin_row;
    end
    if (best < rmin) begin
      rmin     = best;
      rmin_row = k;
    end

    del = sat_add(above, CW'(cfg_i.delete_cost));
    if (best > del) begin
      best = del;
      move = lcd_pkg::MOVE_DEL;
      prow = rc;
    end
    if (best < rmin) begin
      rmin     = best;
      rmin_row = k;
    end

    last = (k >= rows_i);
  end

  always_comb begin
    first_column_d = first_column_q;
    row_counter_d  = row_counter_q;
    diag_d         = diag_q;
    above_d        = above_q;
    run_min_d      = run_min_q;
    run_min_row_d  = run_min_row_q;
    top_d          = top_q;
    if (fire_i) begin
      first_column_d = last ? 1'b0 : first_col;
      row_counter_d  = last ? '0 : k;
      diag_d         = prevk;
      above_d        = best;
      run_min_d      = rmin;
      run_min_row_d  = rmin_row;
      top_d          = start ? top : top_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_column_q <= 1'b1;
      row_counter_q  <= '0;
      diag_q         <= '0;
      above_q        <= '0;
      run_min_q      <= '0;
      run_min_row_q  <= '0;
    end else begin
      first_column_q <= first_column_d;
      row_counter_q  <= row_counter_d;
      diag_q         <= diag_d;
      above_q        <= above_d;
      run_min_q      <= run_min_d;
      run_min_row_q  <= run_min_row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
  end

  assign mem_we_o     = fire_i;
  assign mem_waddr_o  = AW'(rc);
  assign mem_wdata_o  = best;
  assign row_next_o   = row_counter_d;
  assign cell_cost_o  = best;
  assign pred_move_o  = move;
  assign pred_row_o   = prow;
  assign row_index_o  = k;
  assign column_end_o = last;

endmodule

### sv/line_diff_cost_dp_cell.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Line diff cost cell: computes one cell of an edit distance matrix with block delete per
// transaction, column by column, keeping the previous column in an internal memory of
// MAX_ROWS entries and row zero of each column in a register. A cell transaction is taken
// into an input register; when it fires, its result is loaded into the result register,
// from which it is offered. One cell is accepted every cycle while the result register is
// free or its result is taken; that rate is set by the update of the diagonal, upper and
// running-minimum registers that link each cell to the one before it. The memory read for
// the next cell is issued in the cycle the current cell is computed, so the fetch does not
// hold up the next cell. There is no clearing pass after reset; the first cell of a matrix
// takes its previous column from the configuration.
module line_diff_cost_dp_cell #(
  parameter int unsigned MAX_ROWS  = 1024,
  parameter int unsigned COST_BITS = 24
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lcd_pkg::APB_AW-1:0]  paddr,
  input  logic [lcd_pkg::APB_DW-1:0]  pwdata,
  output logic [lcd_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  lcd_cell_if.sink                    cell_i,
  lcd_result_if.source                result_o
);

  localparam int unsigned RW = $clog2(MAX_ROWS + 1);
  localparam int unsigned AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  function automatic logic [RW-1:0] rows_limit(input logic [10:0] rows);
    logic [RW-1:0] n;
    if (rows == '0) begin
      n = RW'(1);
    end else if (32'(rows) > 32'(MAX_ROWS)) begin
      n = RW'(MAX_ROWS);
    end else begin
      n = RW'(rows);
    end
    return n;
  endfunction

  lcd_pkg::lcd_cfg_t cfg, cfg_next;
  logic [RW-1:0]     rows_now, rows_next;

  logic        in_valid_q;
  logic [15:0] in_sub_cost_q;
  logic [15:0] in_line_length_q;
  logic        in_first_cell_q;
  logic        fire;

  logic [COST_BITS-1:0] mem_rdata, mem_wdata;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic                 mem_we;
  logic [RW-1:0]        row_next;

  logic [COST_BITS-1:0] dp_cost;
  lcd_pkg::lcd_move_e   dp_move;
  logic [RW-1:0]        dp_pred_row, dp_row_index;
  logic                 dp_column_end;

  logic               out_valid_q;
  logic [23:0]        cell_cost_q;
  lcd_pkg::lcd_move_e pred_move_q;
  logic [10:0]        pred_row_q;
  logic [10:0]        row_index_q;
  logic               column_end_q;

  logic               fwd_hit;
  logic               near_move;
  logic [10:0]        prev_row;

  lcd_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .cfg_o      (cfg),
    .cfg_next_o (cfg_next)
  );

  assign rows_now  = rows_limit(cfg.rows_in_use);
  assign rows_next = rows_limit(cfg_next.rows_in_use);

  assign fire         = in_valid_q && (!out_valid_q || result_o.ready);
  assign cell_i.ready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (cell_i.ready) begin
      in_valid_q <= cell_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cell_i.valid && cell_i.ready) begin
      in_sub_cost_q    <= cell_i.sub_cost;
      in_line_length_q <= cell_i.line_length;
      in_first_cell_q  <= cell_i.first_cell;
    end
  end

  // The next cell's previous-column entry is fetched from the row state after this edge.
  assign mem_raddr = (row_next >= rows_next) ? '0 : AW'(row_next);

  lcd_col_mem #(
    .DEPTH (MAX_ROWS),
    .AW    (AW),
    .DW    (COST_BITS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  lcd_cell_dp #(
    .MAX_ROWS  (MAX_ROWS),
    .COST_BITS (COST_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .sub_cost_i    (in_sub_cost_q),
    .line_length_i (in_line_length_q),
    .first_cell_i  (in_first_cell_q),
    .cfg_i         (cfg),
    .rows_i        (rows_now),
    .mem_rdata_i   (mem_rdata),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .row_next_o    (row_next),
    .cell_cost_o   (dp_cost),
    .pred_move_o   (dp_move),
    .pred_row_o    (dp_pred_row),
    .row_index_o   (dp_row_index),
    .column_end_o  (dp_column_end)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      cell_cost_q  <= 24'(dp_cost);
      pred_move_q  <= dp_move;
      pred_row_q   <= 11'(dp_pred_row);
      row_index_q  <= 11'(dp_row_index);
      column_end_q <= dp_column_end;
    end
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.cell_cost  = cell_cost_q;
  assign result_o.pred_move  = pred_move_q;
  assign result_o.pred_row   = pred_row_q;
  assign result_o.row_index  = row_index_q;
  assign result_o.column_end = column_end_q;

  assign fwd_hit   = mem_we && (mem_raddr == mem_waddr);
  assign near_move = (pred_move_q == lcd_pkg::MOVE_SUB) || (pred_move_q == lcd_pkg::MOVE_DEL);
  assign prev_row  = row_index_q - 11'd1;

  `LCD_ASSERT_NEXT(a_cell_gives_result, clk_i, rst_ni, fire, out_valid_q)
  `LCD_ASSERT_NEXT(a_store_forward, clk_i, rst_ni, fwd_hit, mem_rdata == $past(mem_wdata))
  `LCD_ASSERT(a_pred_row_above, clk_i, rst_ni, out_valid_q && near_move |-> pred_row_q == prev_row)

endmodule

### tb/lcd_cell_checker.sv
`timescale 1ns / 1ps

module lcd_cell_checker #(
  parameter int unsigned MAX_ROWS = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lcd_pkg::APB_AW-1:0] paddr,
  input  logic [lcd_pkg::APB_DW-1:0] pwdata,
  input  logic                       pready,
  lcd_cell_if                        cell_i,
  lcd_result_if                      result_i,
  output int                         fail_count_o,
  output int                         pending_o
);

  localparam logic [23:0] COST_MAX = 24'hFFFFFF;

  typedef struct packed {
    logic [23:0]        cost;
    lcd_pkg::lcd_move_e move;
    logic [10:0]        prev_row;
    logic [10:0]        row;
    logic               col_end;
  } cell_result_t;

  lcd_pkg::lcd_cfg_t cfg;
  logic [23:0]  col_mem [0:MAX_ROWS];
  logic         first_col;
  logic [10:0]  row_cnt;
  logic [23:0]  diag;
  logic [23:0]  above;
  logic [23:0]  run_min;
  logic [10:0]  run_min_row;
  cell_result_t expected_cells [$];
  cell_result_t want;
  int           errors = 0;

  function automatic logic [23:0] cost_add(input logic [23:0] a, input logic [23:0] b);
    logic [24:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[24] ? COST_MAX : s[23:0];
  endfunction

  function automatic logic [23:0] prior_cost(input logic [10:0] row);
    if (!first_col) return col_mem[row];
    if (row == 11'd0) return '0;
    if (row == 11'd1) return cost_add('0, 24'(cfg.delete_cost));
    return cost_add('0, 24'(cfg.block_delete_cost));
  endfunction

  function automatic cell_result_t score_cell(input logic [15:0] sub, input logic [15:0] len,
                                              input logic restart);
    logic [10:0]  n;
    logic [10:0]  k;
    logic [23:0]  p0;
    logic [23:0]  top_cost;
    logic [23:0]  prevk;
    logic [23:0]  via_sub;
    logic [23:0]  via_add;
    logic [23:0]  best;
    logic [23:0]  blk;
    logic [23:0]  del;
    cell_result_t r;
    n = cfg.rows_in_use;
    if (n == 11'd0) n = 11'd1;
    if (n > MAX_ROWS) n = 11'(MAX_ROWS);
    if (restart) begin
      first_col = 1'b1;
      row_cnt = '0;
    end
    if (row_cnt >= n) row_cnt = '0;
    if (row_cnt == 11'd0) begin
      p0 = prior_cost(11'd0);
      top_cost = cost_add(cost_add(p0, 24'(cfg.add_base_cost)), 24'(len));
      col_mem[0] = top_cost;
      diag = p0;
      above = top_cost;
      run_min = top_cost;
      run_min_row = '0;
    end
    k = row_cnt + 11'd1;
    prevk = prior_cost(k);
    via_sub = cost_add(diag, 24'(sub));
    via_add = cost_add(cost_add(prevk, 24'(cfg.add_base_cost)), 24'(len));
    if (via_sub <= via_add) begin
      best = via_sub;
      r.move = lcd_pkg::MOVE_SUB;
      r.prev_row = k - 11'd1;
    end else begin
      best = via_add;
      r.move = lcd_pkg::MOVE_ADD;
      r.prev_row = k;
    end
    blk = cost_add(run_min, 24'(cfg.block_delete_cost));
    if (best > blk) begin
      best = blk;
      r.move = lcd_pkg::MOVE_BLOCK_DEL;
      r.prev_row = run_min_row;
    end
    if (best < run_min) begin
      run_min = best;
      run_min_row = k;
    end
    del = cost_add(above, 24'(cfg.delete_cost));
    if (best > del) begin
      best = del;
      r.move = lcd_pkg::MOVE_DEL;
      r.prev_row = k - 11'd1;
    end
    if (best < run_min) begin
      run_min = best;
      run_min_row = k;
    end
    diag = prevk;
    above = best;
    col_mem[k] = best;
    r.cost = best;
    r.row = k;
    r.col_end = (k >= n);
    if (k >= n) begin
      row_cnt = '0;
      first_col = 1'b0;
    end else begin
      row_cnt = k;
    end
    return r;
  endfunction

  function automatic void check_field(input string field, input logic [31:0] exp_val,
                                      input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, exp_val, act_val);
      errors++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg.rows_in_use = lcd_pkg::RESET_ROWS_IN_USE;
      cfg.delete_cost = lcd_pkg::RESET_DELETE_COST;
      cfg.block_delete_cost = lcd_pkg::RESET_BLOCK_DELETE_COST;
      cfg.add_base_cost = lcd_pkg::RESET_ADD_BASE_COST;
      for (int i = 0; i <= MAX_ROWS; i++) col_mem[i] = '0;
      first_col = 1'b1;
      row_cnt = '0;
      diag = '0;
      above = '0;
      run_min = '0;
      run_min_row = '0;
      expected_cells.delete();
      pending_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          lcd_pkg::REG_ROWS_IN_USE: cfg.rows_in_use = pwdata[10:0];
          lcd_pkg::REG_DELETE_COST: cfg.delete_cost = pwdata[7:0];
          lcd_pkg::REG_BLOCK_DELETE_COST: cfg.block_delete_cost = pwdata[7:0];
          lcd_pkg::REG_ADD_BASE_COST: cfg.add_base_cost = pwdata[7:0];
          default: ;
        endcase
      end
      if (cell_i.valid && cell_i.ready) begin
        expected_cells.push_back(score_cell(cell_i.sub_cost, cell_i.line_length,
                                            cell_i.first_cell));
      end
      if (result_i.valid && result_i.ready) begin
        if (expected_cells.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual cost %0d row %0d", $time,
                   result_i.cell_cost, result_i.row_index);
          errors++;
        end else begin
          want = expected_cells.pop_front();
          check_field("cell_cost", 32'(want.cost), 32'(result_i.cell_cost));
          check_field("pred_move", 32'(want.move), 32'(result_i.pred_move));
          check_field("pred_row", 32'(want.prev_row), 32'(result_i.pred_row));
          check_field("row_index", 32'(want.row), 32'(result_i.row_index));
          check_field("column_end", 32'(want.col_end), 32'(result_i.column_end));
        end
      end
      pending_o <= expected_cells.size();
    end
    fail_count_o <= errors;
  end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int WATCHDOG_CYCLES = 2000;

  typedef enum logic [1:0] {
    LEN_SHORT = 2'd0,
    LEN_ANY   = 2'd1,
    LEN_LONG  = 2'd2
  } len_mode_e;

  typedef enum logic [1:0] {
    STALL_NONE     = 2'd0,
    STALL_LIGHT    = 2'd1,
    STALL_HEAVY    = 2'd2,
    STALL_PERIODIC = 2'd3
  } stall_mode_e;

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [lcd_pkg::APB_AW-1:0] paddr;
  logic [lcd_pkg::APB_DW-1:0] pwdata;
  logic [lcd_pkg::APB_DW-1:0] prdata;
  logic                       pready;
  int                         fail_count;
  int                         pending;

  int unsigned cur_rows = 1;
  int unsigned col_pos = 0;
  int unsigned burst_left = 0;
  logic        must_restart = 1'b0;
  logic        gapless = 1'b0;
  logic [15:0] col_len = '0;
  int unsigned idle_cycles = 0;
  int unsigned stall_left = 0;
  stall_mode_e stall_mode = STALL_NONE;

  lcd_cell_if   cell_if ();
  lcd_result_if res_if ();

  line_diff_cost_dp_cell u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .cell_i   (cell_if),
    .result_o (res_if)
  );

  lcd_cell_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .cell_i       (cell_if),
    .result_i     (res_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE: res_if.ready <= 1'b1;
      STALL_LIGHT: res_if.ready <= ($urandom_range(0, 3) != 0);
      STALL_HEAVY: res_if.ready <= ($urandom_range(0, 3) == 0);
      default: res_if.ready <= (stall_left % 3 == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if ((cell_if.valid && cell_if.ready) || (res_if.valid && res_if.ready) ||
        (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_CYCLES) begin
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_CYCLES);
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  // A column that grows past what the previous column wrote must start a new matrix.
  task automatic set_config(input logic [10:0] rows, input logic [7:0] del,
                            input logic [7:0] blk, input logic [7:0] add);
    apb_write(lcd_pkg::REG_ROWS_IN_USE, {21'd0, rows});
    apb_write(lcd_pkg::REG_DELETE_COST, {24'd0, del});
    apb_write(lcd_pkg::REG_BLOCK_DELETE_COST, {24'd0, blk});
    apb_write(lcd_pkg::REG_ADD_BASE_COST, {24'd0, add});
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (32'(rows) > cur_rows) must_restart = 1'b1;
    cur_rows = 32'(rows);
  endtask

  task automatic send_cell(input logic [15:0] sub, input logic [15:0] len,
                           input logic restart);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gapless || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        cell_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    if (restart || must_restart || col_pos >= cur_rows) col_pos = 0;
    cell_if.valid <= 1'b1;
    cell_if.sub_cost <= sub;
    cell_if.line_length <= len;
    cell_if.first_cell <= restart || must_restart;
    must_restart = 1'b0;
    col_pos++;
    do @(posedge clk_i); while (!cell_if.ready);
  endtask

  task automatic drain();
    cell_if.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  function automatic logic [15:0] pick_len(input len_mode_e mode);
    case (mode)
      LEN_SHORT: return 16'($urandom_range(0, 40));
      LEN_LONG: return 16'hFFFF - 16'($urandom_range(0, 2));
      default: return ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 40)) : 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_cost();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'hFF;
      2, 3: return 8'($urandom_range(0, 16));
      default: return 8'($urandom);
    endcase
  endfunction

  // The line length is held for a whole column, except for an occasional change mid column.
  task automatic send_random_cell(input len_mode_e mode);
    logic        restart;
    logic [15:0] sub;
    restart = (mode != LEN_LONG) && ($urandom_range(0, 39) == 0);
    if (restart || must_restart || col_pos == 0 || col_pos >= cur_rows) begin
      col_len = pick_len(mode);
    end else if ($urandom_range(0, 19) == 0) begin
      col_len = pick_len(LEN_ANY);
    end
    case ($urandom_range(0, 5))
      0: sub = '0;
      1: sub = 16'hFFFF;
      2, 3: sub = 16'($urandom_range(0, 64));
      default: sub = 16'($urandom);
    endcase
    send_cell(sub, col_len, restart);
  endtask

  task automatic run_phase(input logic [10:0] rows, input int unsigned count,
                           input len_mode_e mode);
    set_config(rows, pick_cost(), pick_cost(), pick_cost());
    gapless = ($urandom_range(0, 3) == 0);
    repeat (count) send_random_cell(mode);
    drain();
  endtask

  initial begin
    rst_ni <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    cell_if.valid <= 1'b0;
    cell_if.sub_cost <= '0;
    cell_if.line_length <= '0;
    cell_if.first_cell <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_cell(16'd0, 16'd0, 1'b1);
    send_cell(16'hFFFF, 16'hFFFF, 1'b0);
    send_cell(16'd0, 16'hFFFF, 1'b0);
    send_cell(16'hFFFF, 16'd0, 1'b0);
    drain();

    set_config(11'd4, 8'd0, 8'd255, 8'd0);
    send_cell(16'hFFFF, 16'd0, 1'b1);
    send_cell(16'd0, 16'd0, 1'b0);
    send_cell(16'hFFFF, 16'd0, 1'b0);
    send_cell(16'd1, 16'd0, 1'b0);
    send_cell(16'd5, 16'd3, 1'b0);
    send_cell(16'hFFFF, 16'd3, 1'b1);
    send_cell(16'd2, 16'd3, 1'b0);
    drain();

    set_config(11'd6, 8'd255, 8'd0, 8'd255);
    send_cell(16'hFFFF, 16'd100, 1'b0);
    send_cell(16'hFFFF, 16'd100, 1'b0);
    send_cell(16'd0, 16'd100, 1'b0);
    send_cell(16'hFFFF, 16'd100, 1'b0);
    send_cell(16'hFFFF, 16'd100, 1'b0);
    drain();

    // Shrinking below the current row starts a new column; shrinking above it ends this one early.
    set_config(11'd3, 8'd255, 8'd0, 8'd255);
    send_cell(16'd7, 16'd20, 1'b0);
    drain();
    set_config(11'd2, 8'd1, 8'd2, 8'd3);
    send_cell(16'd9, 16'd20, 1'b0);
    send_cell(16'd0, 16'd5, 1'b0);
    send_cell(16'hFFFF, 16'd5, 1'b0);
    drain();

    repeat (3) begin
      run_phase(11'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 1023) : $urandom_range(1, 12)),
                $urandom_range(30, 60), len_mode_e'($urandom_range(0, 1)));
    end
    run_phase(11'd1, 40, LEN_LONG);
    run_phase(11'd1024, 1024, LEN_SHORT);

    drain();
    repeat (5) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### line_diff_cost_dp_cell.f
+incdir+sv
sv/lcd_pkg.sv
sv/lcd_cell_if.sv
sv/lcd_result_if.sv
sv/lcd_cfg_regs.sv
sv/lcd_col_mem.sv
sv/lcd_cell_dp.sv
sv/line_diff_cost_dp_cell.sv
tb/lcd_cell_checker.sv
tb/tb.sv
